FILE: src/mbpc_pkg.sv
package mbpc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned BTN_W     = 2;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned TIMER_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned TDATA_W   = 8;

  localparam int unsigned NUM_BUTTONS_DEF = 4;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_PUSH    = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  // Press kinds
  localparam logic PRESS_SHORT = 1'b0;
  localparam logic PRESS_LONG  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PUSH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICK = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0]   LONG_PUSH_RST   = 8'd10;
  localparam logic [CNT_W-1:0]   SHORT_MIN_RST   = 8'd3;
  localparam logic [TIMER_W-1:0] WINDOW_TICK_RST = 16'd500;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0]   long_push_count;
    logic [CNT_W-1:0]   short_min_count;
    logic [TIMER_W-1:0] release_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              press_kind;
    logic [MASK_W-1:0] button_mask;
  } res_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [BTN_W-1:0] button_id;
  } item_t;

endpackage

FILE: src/mbpc_in_stage.sv
module mbpc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  mbpc_pkg::item_t in_item,
  input  logic            advance,
  output logic            s1_valid,
  output mbpc_pkg::item_t s1_item
);
  import mbpc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  // Take a new item when empty or when the held one moves on
  assign in_tready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
      if (in_tvalid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: src/mbpc_core.sv
module mbpc_core #(
  parameter int unsigned NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  mbpc_pkg::item_t item,
  input  mbpc_pkg::cfg_t  cfg,
  output mbpc_pkg::res_t  res
);
  import mbpc_pkg::*;

  logic [CNT_W-1:0]   count_r   [NUM_BUTTONS];
  logic [CNT_W-1:0]   count_nxt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] long_r, long_nxt;
  logic [NUM_BUTTONS-1:0] pend_r, pend_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               active_r, active_nxt;

  logic [NUM_BUTTONS-1:0] hit;
  logic [NUM_BUTTONS-1:0] over_half;
  logic [NUM_BUTTONS+MASK_W-1:0] wide_mask;
  logic [CNT_W-1:0]   sel_cnt;
  logic               sel_long;
  logic [CNT_W-1:0]   inc_cnt;
  logic [CNT_W-1:0]   half;
  logic               btn_ok;

  always_comb begin
    // Decode the addressed button; ids beyond the group hit nothing
    sel_cnt  = '0;
    sel_long = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      hit[i] = ({{(CNT_W-BTN_W){1'b0}}, item.button_id} == CNT_W'(i));
      if (hit[i]) begin
        sel_cnt  = count_r[i];
        sel_long = long_r[i];
      end
    end
    btn_ok  = |hit;
    inc_cnt = (sel_cnt == CNT_MAX) ? CNT_MAX : sel_cnt + 1'b1;
    half    = cfg.long_push_count >> 1;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      over_half[i] = (hit[i] ? inc_cnt : count_r[i]) > half;
    end

    count_nxt  = count_r;
    long_nxt   = long_r;
    pend_nxt   = pend_r;
    timer_nxt  = timer_r;
    active_nxt = active_r;
    wide_mask  = '0;
    res        = '0;

    case (req_t'(item.req_type))
      REQ_TICK: begin
        if (active_r) begin
          if (timer_r > TIMER_W'(1)) begin
            timer_nxt = timer_r - 1'b1;
          end else begin
            wide_mask       = {{MASK_W{1'b0}}, pend_r};
            res.valid       = 1'b1;
            res.press_kind  = PRESS_SHORT;
            res.button_mask = wide_mask[MASK_W-1:0];
            pend_nxt        = '0;
            timer_nxt       = '0;
            active_nxt      = 1'b0;
          end
        end
      end
      REQ_PUSH: begin
        if (btn_ok) begin
          if (inc_cnt > cfg.long_push_count) begin
            wide_mask       = {{MASK_W{1'b0}}, over_half};
            res.valid       = 1'b1;
            res.press_kind  = PRESS_LONG;
            res.button_mask = wide_mask[MASK_W-1:0];
            long_nxt        = over_half;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              count_nxt[i] = '0;
            end
          end else begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (hit[i]) begin
                count_nxt[i] = inc_cnt;
              end
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (btn_ok) begin
          if (sel_cnt > cfg.short_min_count && !sel_long) begin
            pend_nxt = pend_r | hit;
            if (!active_r) begin
              active_nxt = 1'b1;
              timer_nxt  = cfg.release_window_ticks;
            end
          end
          long_nxt = long_r & ~hit;
          for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (hit[i]) begin
              count_nxt[i] = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        count_r[i] <= '0;
      end
      long_r   <= '0;
      pend_r   <= '0;
      timer_r  <= '0;
      active_r <= 1'b0;
    end else if (fire) begin
      count_r  <= count_nxt;
      long_r   <= long_nxt;
      pend_r   <= pend_nxt;
      timer_r  <= timer_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

FILE: src/multi_button_press_classifier.sv
// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+-----------------------------------------
// in_      | in  | in_tvalid/tready   | tuser[1:0] req_type, tdata[1:0] button_id
// out_     | out | out_tvalid/tready  | tuser press_kind, tdata[3:0] button_mask
// cfg_     | in  | cfg_we             | cfg_index, cfg_wdata[15:0]
//
// One item per cycle while the output is not stalled: an input register
// holds the transfer, the per-button compare and state update is
// combinational, and the result lands in the output register when the
// held item advances out of the input register.
// Items that produce no press leave the output register untouched.
// Reset (synchronous, active low) clears all counts, marks, the window
// timer and both pipeline valids, and restores the register defaults.
// A stalled output holds the input register; input stalls only then.
module multi_button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mbpc_pkg::TDATA_W-1:0]         in_tdata,   // [1:0] button_id
  input  logic [mbpc_pkg::REQ_W-1:0]           in_tuser,   // [1:0] req_type
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mbpc_pkg::TDATA_W-1:0]         out_tdata,  // [3:0] button_mask
  output logic                                 out_tuser,  // [0] press_kind
  input  logic                                 cfg_we,
  input  logic [mbpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbpc_pkg::CFG_W-1:0]           cfg_wdata
);
  import mbpc_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t in_item, s1_item;
  res_t  res;
  logic  s1_valid;
  logic  advance;
  logic  out_valid_r, out_valid_nxt;
  logic  out_kind_r, out_kind_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;

  // Configuration writes: take the low bits of the write data
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PUSH:   cfg_nxt.long_push_count      = cfg_wdata[CNT_W-1:0];
        CFG_SHORT_MIN:   cfg_nxt.short_min_count      = cfg_wdata[CNT_W-1:0];
        CFG_WINDOW_TICK: cfg_nxt.release_window_ticks = cfg_wdata[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_push_count      <= LONG_PUSH_RST;
      cfg_r.short_min_count      <= SHORT_MIN_RST;
      cfg_r.release_window_ticks <= WINDOW_TICK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_item = item_t'({in_tuser, in_tdata[BTN_W-1:0]});

  // Advance the held item whenever the output register is free or draining
  assign advance = s1_valid && (!out_valid_r || out_tready);

  mbpc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item)
  );

  mbpc_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (s1_item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Output register: load a press, drop the valid once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_mask_nxt  = out_mask_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && res.valid) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res.press_kind;
      out_mask_nxt  = res.button_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(TDATA_W-MASK_W){1'b0}}, out_mask_r};

  // A long press always includes the button that crossed the limit
  a_long_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == PRESS_LONG) |-> out_tdata[MASK_W-1:0] != '0)
    else $error("long press with empty mask");

  // A new result only follows an item leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(advance))
    else $error("result without a processed item");

  // Input stalls only behind a held item and a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid && out_tvalid && !out_tready)
    else $error("input stalled without back-pressure");

endmodule

FILE: test/mbpc_checker.sv
`timescale 1ns / 100ps

// Watches the three ports of the press classifier, predicts the presses
// and compares every output transfer against the oldest prediction.
module mbpc_checker #(
  parameter int unsigned NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [mbpc_pkg::TDATA_W-1:0]   in_tdata,   // [1:0] button_id
  input  logic [mbpc_pkg::REQ_W-1:0]     in_tuser,   // [1:0] req_type
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [mbpc_pkg::TDATA_W-1:0]   out_tdata,  // [3:0] button_mask
  input  logic                           out_tuser,  // [0] press_kind
  input  logic                           cfg_we,
  input  logic [mbpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbpc_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             items_seen,
  output int                             shorts_seen,
  output int                             longs_seen
);
  import mbpc_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [MASK_W-1:0] mask;
  } press_t;

  press_t presses_due[$];

  // Predicted register and button state
  logic [CNT_W-1:0]   lim_long;
  logic [CNT_W-1:0]   lim_short;
  logic [TIMER_W-1:0] win_len;
  logic [CNT_W-1:0]   push_cnt  [NUM_BUTTONS];
  logic               long_mark [NUM_BUTTONS];
  logic               rel_pend  [NUM_BUTTONS];
  logic [TIMER_W-1:0] win_timer;
  logic               win_open;

  bit     fired;
  press_t made_press;
  press_t want_press;

  initial begin
    fail_count  = 0;
    pending     = 0;
    items_seen  = 0;
    shorts_seen = 0;
    longs_seen  = 0;
  end

  function automatic void report(string what, int want, int got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  // Advance the predicted state by one input item
  task automatic classify(input logic [REQ_W-1:0] req, input logic [BTN_W-1:0] btn,
                          output bit hit, output press_t p);
    logic [CNT_W-1:0] half;
    int unsigned      b;
    hit  = 1'b0;
    p    = '0;
    half = lim_long >> 1;
    b    = 32'(btn);
    case (req)
      REQ_TICK: begin
        if (win_open) begin
          if (win_timer > 1) begin
            win_timer = win_timer - 1'b1;
          end else begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              if (i < MASK_W && rel_pend[i])
                p.mask[i] = 1'b1;
              rel_pend[i] = 1'b0;
            end
            win_timer = '0;
            win_open  = 1'b0;
            p.kind    = PRESS_SHORT;
            hit       = 1'b1;
          end
        end
      end
      REQ_PUSH: begin
        if (b < NUM_BUTTONS) begin
          if (push_cnt[b] != CNT_MAX)
            push_cnt[b] = push_cnt[b] + 1'b1;
          if (push_cnt[b] > lim_long) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
              long_mark[i] = (push_cnt[i] > half);
              if (i < MASK_W)
                p.mask[i] = long_mark[i];
              push_cnt[i] = '0;
            end
            p.kind = PRESS_LONG;
            hit    = 1'b1;
          end
        end
      end
      REQ_RELEASE: begin
        if (b < NUM_BUTTONS) begin
          if (push_cnt[b] > lim_short && !long_mark[b]) begin
            rel_pend[b] = 1'b1;
            if (!win_open) begin
              win_open  = 1'b1;
              win_timer = win_len;
            end
          end
          long_mark[b] = 1'b0;
          push_cnt[b]  = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_long  = LONG_PUSH_RST;
      lim_short = SHORT_MIN_RST;
      win_len   = WINDOW_TICK_RST;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        push_cnt[i]  = '0;
        long_mark[i] = 1'b0;
        rel_pend[i]  = 1'b0;
      end
      win_timer = '0;
      win_open  = 1'b0;
      presses_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LONG_PUSH:   lim_long  = cfg_wdata[CNT_W-1:0];
          CFG_SHORT_MIN:   lim_short = cfg_wdata[CNT_W-1:0];
          CFG_WINDOW_TICK: win_len   = cfg_wdata[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (presses_due.size() == 0) begin
          report("unexpected press", 0, int'({out_tuser, out_tdata}));
        end else begin
          want_press = presses_due.pop_front();
          if (out_tuser !== want_press.kind)
            report("press_kind", int'(want_press.kind), int'(out_tuser));
          if (out_tdata !== {{(TDATA_W-MASK_W){1'b0}}, want_press.mask})
            report("button_mask", int'(want_press.mask), int'(out_tdata));
        end
      end
      if (in_tvalid && in_tready) begin
        items_seen++;
        classify(in_tuser, in_tdata[BTN_W-1:0], fired, made_press);
        if (fired) begin
          presses_due.insert(presses_due.size(), made_press);
          if (made_press.kind == PRESS_LONG)
            longs_seen++;
          else
            shorts_seen++;
        end
      end
    end
    pending = presses_due.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mbpc_pkg::*;

  // Request code the block must ignore
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Cycles to let the two-stage pipeline empty before touching registers
  localparam int SETTLE_CYCLES = 8;
  // Watchdog: cycles with no transfer on either channel
  localparam int STALL_LIMIT   = 2000;
  // Length of the deliberate output hold-off
  localparam int HOLD_CYCLES   = 400;
  // Random items per phase
  localparam int PHASE_ITEMS   = 230;
  localparam int NUM_PHASES    = 6;
  // Window wider than one byte, run to its end
  localparam int WIDE_WINDOW   = 260;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic [REQ_W-1:0]     in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  int fail_count;
  int pending;
  int items_seen;
  int shorts_seen;
  int longs_seen;

  // Idling mix, in percent of cycles
  int tx_idle_pct = 6;
  int rx_idle_pct = 63;
  bit hold_go     = 1'b0;

  // Register values currently in force, used to shape the gestures
  int cur_long  = int'(LONG_PUSH_RST);
  int cur_short = int'(SHORT_MIN_RST);
  int cur_win   = int'(WINDOW_TICK_RST);
  int settings_used = 1;

  multi_button_press_classifier #(
    .NUM_BUTTONS (NUM_BUTTONS_DEF)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  mbpc_checker #(
    .NUM_BUTTONS (NUM_BUTTONS_DEF)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .items_seen  (items_seen),
    .shorts_seen (shorts_seen),
    .longs_seen  (longs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: drop tready at random, or hold it low for a long stretch on
  // request so that the output register and then the input register fill.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: give up once nothing has moved for too long
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item; called and returning at a falling edge. Idle gaps come
  // first, then valid stays up until the transfer completes.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [BTN_W-1:0] btn);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(TDATA_W-BTN_W){1'b0}}, btn};
    do
      @(posedge clk);
    while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted press to arrive, then let the
  // pipeline run dry so that items with no press have left it too.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all three registers back to back; only call while the block is idle
  task automatic set_config(input int lim_long, input int lim_short, input int win);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_PUSH;
    cfg_wdata <= CFG_W'(lim_long);
    @(negedge clk);
    cfg_index <= CFG_SHORT_MIN;
    cfg_wdata <= CFG_W'(lim_short);
    @(negedge clk);
    cfg_index <= CFG_WINDOW_TICK;
    cfg_wdata <= CFG_W'(win);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    cur_long  = lim_long;
    cur_short = lim_short;
    cur_win   = win;
    settings_used++;
  endtask

  // One user gesture: a few buttons pushed for a random time, with some
  // noise mixed in, released in random order, then some ticks to let the
  // release window run.
  task automatic gesture(inout int sent);
    logic [NUM_BUTTONS_DEF-1:0] sel;
    logic [BTN_W-1:0]           b;
    int                         n;
    int                         r;
    sel = NUM_BUTTONS_DEF'($urandom_range(1, (1 << NUM_BUTTONS_DEF) - 1));
    n   = $urandom_range(0, 2 * cur_long + 4);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_item(REQ_TICK, BTN_W'($urandom_range(3)));
      end else if (r < 15) begin
        send_item(REQ_UNUSED, BTN_W'($urandom_range(3)));
      end else if (r < 18) begin
        send_item(REQ_RELEASE, BTN_W'($urandom_range(3)));
      end else begin
        do
          b = BTN_W'($urandom_range(3));
        while (!sel[b]);
        send_item(REQ_PUSH, b);
      end
      sent++;
    end
    b = BTN_W'($urandom_range(3));
    for (int k = 0; k < NUM_BUTTONS_DEF; k++) begin
      if (sel[b]) begin
        send_item(REQ_RELEASE, b);
        sent++;
      end
      b = b + 1'b1;
    end
    n = $urandom_range(0, (cur_win < 40) ? cur_win + 3 : 40);
    for (int k = 0; k < n; k++) begin
      send_item(REQ_TICK, BTN_W'($urandom_range(3)));
      sent++;
    end
  endtask

  initial begin
    int sent;

    // Hold reset once at the start
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: long limit 2 (half 1), short minimum 1, window of 2 ticks
    set_config(2, 1, 2);
    send_item(REQ_TICK, 2'd3);      // tick with no window open
    send_item(REQ_UNUSED, 2'd3);    // unused request type
    send_item(REQ_PUSH, 2'd0);
    send_item(REQ_PUSH, 2'd0);      // count equals the limit: nothing yet
    send_item(REQ_PUSH, 2'd1);
    send_item(REQ_PUSH, 2'd0);      // long press, button 0 only
    send_item(REQ_RELEASE, 2'd0);   // long mark blocks the release
    send_item(REQ_PUSH, 2'd2);
    send_item(REQ_PUSH, 2'd2);
    send_item(REQ_RELEASE, 2'd2);   // opens the window
    send_item(REQ_PUSH, 2'd3);
    send_item(REQ_PUSH, 2'd3);
    send_item(REQ_RELEASE, 2'd3);   // joins the window, no restart
    send_item(REQ_TICK, 2'd0);
    send_item(REQ_TICK, 2'd1);      // short press, buttons 2 and 3
    send_item(REQ_RELEASE, 2'd1);   // count too low
    send_item(REQ_TICK, 2'd2);
    send_item(REQ_PUSH, 2'd1);
    send_item(REQ_PUSH, 2'd2);
    send_item(REQ_PUSH, 2'd2);
    send_item(REQ_PUSH, 2'd1);
    send_item(REQ_PUSH, 2'd1);      // long press, buttons 1 and 2
    settle();

    // Window wider than a byte: one release, then the full run of ticks
    set_config(5, 1, WIDE_WINDOW);
    repeat (3) send_item(REQ_PUSH, 2'd0);
    send_item(REQ_RELEASE, 2'd0);
    repeat (WIDE_WINDOW) send_item(REQ_TICK, 2'd0);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Idling mix: sender light / receiver heavy, then swapped, then none
      case (ph / 2)
        0: begin tx_idle_pct = 6;  rx_idle_pct = 63; end
        1: begin tx_idle_pct = 63; rx_idle_pct = 6;  end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      sent = 0;
      case (ph)
        0: begin
          // Run at the reset defaults first
          set_config(int'(LONG_PUSH_RST), int'(SHORT_MIN_RST), int'(WINDOW_TICK_RST));
        end
        1: begin
          // Low limits: a second push of a button makes a long press, so stall the output
          set_config(1, 0, 1);
          hold_go = 1'b1;
        end
        2: begin
          // High limits: push one button until its count passes the long limit
          set_config(254, 254, 2);
          repeat (255) begin
            send_item(REQ_PUSH, 2'd1);
            sent++;
          end
        end
        3, 4: set_config($urandom_range(2, 20), $urandom_range(0, 12),
                         $urandom_range(1, 30));
        default: set_config($urandom_range(1, 40), $urandom_range(0, 40),
                            $urandom_range(1, 60));
      endcase
      while (sent < PHASE_ITEMS)
        gesture(sent);
      settle();
    end

    $display("covered %0d input transfers, %0d presses (%0d short, %0d long)",
             items_seen, shorts_seen + longs_seen, shorts_seen, longs_seen);
    $display("over %0d register settings, three idling mixes and a %0d-cycle hold-off",
             settings_used, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: multi_button_press_classifier.f
src/mbpc_pkg.sv
src/mbpc_in_stage.sv
src/mbpc_core.sv
src/multi_button_press_classifier.sv
test/mbpc_checker.sv
test/tb_top.sv
